// ===== hdl/nita_pkg.sv =====
`timescale 1ns / 1ps

package nita_pkg;

    localparam int THREADS        = 4;
    localparam int SCOPES         = 16;
    localparam int ENTRIES        = THREADS * SCOPES;
    localparam int TID_W          = 2;
    localparam int SID_W          = 4;
    localparam int KEY_W          = TID_W + SID_W;
    localparam int CNT_W          = 5;
    localparam int TICK_W         = 32;
    localparam int HIT_W          = 16;
    localparam int AGE_W          = 7;
    localparam logic [AGE_W-1:0] REFRESH_FRAMES = 7'd60;
    localparam logic CMD_RECORD   = 1'b0;
    localparam logic CMD_FRAME    = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [TID_W-1:0]  thread_num;
        logic [SID_W-1:0]  scope_id;
        logic [TICK_W-1:0] start_tick;
        logic [TICK_W-1:0] elapsed_ticks;
    } in_t;

    typedef struct packed {
        logic              scope_valid;
        logic [SID_W-1:0]  scope_index;
        logic [TICK_W-1:0] total_ticks;
        logic [HIT_W-1:0]  hit_count;
        logic [TICK_W-1:0] frame_ticks;
        logic [TICK_W-1:0] max_frame_ticks;
        logic              last;
    } out_t;

    typedef struct packed {
        logic [TICK_W-1:0] main_total;
        logic [HIT_W-1:0]  hits;
        logic [TICK_W-1:0] total;
    } acc_t;

    typedef struct packed {
        logic [TICK_W-1:0] start;
        logic [TICK_W-1:0] elapsed;
    } open_t;

endpackage

// ===== hdl/nested_interval_time_accumulator_unit.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Handshake           | Payload
// cfg     | in  | cfg_wr_en           | cfg_wr_data (scopes_in_use)
// in      | in  | in_valid / in_stall | in_data (in_t)
// out     | out | out_valid/out_stall | out_data (out_t)
// A sample reads the open-sample and scope memories, then modifies and
// writes back. A frame end walks all 64 open entries, then, if scopes are in
// use, the scope totals for the frame maximum and the held-maximum update,
// then emits one result per scope in use (one if none), waiting on stall.
// Reset is asynchronous and needs no clearing pass. A result waiting in the
// output register does not block input.
module nested_interval_time_accumulator_unit
    import nita_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SMP    = 4'd1;
    localparam logic [3:0] ST_CL_RD  = 4'd2;
    localparam logic [3:0] ST_CL_WR  = 4'd3;
    localparam logic [3:0] ST_MX_RD  = 4'd4;
    localparam logic [3:0] ST_MX_CMP = 4'd5;
    localparam logic [3:0] ST_MX_UPD = 4'd6;
    localparam logic [3:0] ST_EM_RD  = 4'd7;
    localparam logic [3:0] ST_EM_LD  = 4'd8;

    open_t open_mem [ENTRIES];
    acc_t  acc_mem  [SCOPES];

    logic [3:0]         state_reg, state_next;
    logic [CNT_W-1:0]   scopes_reg;
    logic [ENTRIES-1:0] open_flag_reg, open_flag_next;
    logic [SCOPES-1:0]  acc_vld_reg, acc_vld_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [TICK_W-1:0]  st_reg, st_next, el_reg, el_next;
    logic [SID_W-1:0]   idx_reg, idx_next;
    logic [TICK_W-1:0]  frame_reg, frame_next;
    logic [TICK_W-1:0]  held_reg, held_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg, out_next;

    open_t              open_rdata_reg;
    acc_t               acc_rdata_reg;
    logic [KEY_W-1:0]   open_raddr;
    logic [SID_W-1:0]   acc_raddr;
    logic               open_we, acc_we;
    open_t              open_wdata;
    acc_t               acc_wdata;

    logic [CNT_W-1:0]   n_act;
    logic [SID_W-1:0]   key_sid;
    acc_t               acc_cur;
    logic [TICK_W-1:0]  open_end;
    logic               nested;
    logic [AGE_W-1:0]   age_inc;
    logic               is_last;

    assign n_act = (scopes_reg > CNT_W'(SCOPES)) ? CNT_W'(SCOPES) : scopes_reg;
    assign key_sid = key_reg[SID_W-1:0];
    assign acc_cur = acc_vld_reg[key_sid] ? acc_rdata_reg : '0;
    assign open_end = open_rdata_reg.start + open_rdata_reg.elapsed;
    assign nested = open_flag_reg[key_reg] && (st_reg >= open_rdata_reg.start)
                    && (st_reg < open_end);
    assign age_inc = age_reg + AGE_W'(1);
    assign is_last = (n_act == '0) || ({1'b0, idx_reg} == n_act - CNT_W'(1));

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        open_rdata_reg <= open_mem[open_raddr];
        acc_rdata_reg  <= acc_mem[acc_raddr];
        if (open_we)
        begin
            open_mem[key_reg] <= open_wdata;
        end
        if (acc_we)
        begin
            acc_mem[key_sid] <= acc_wdata;
        end
    end

    always_comb
    begin
        acc_t closed;
        closed            = acc_cur;
        closed.total      = acc_cur.total + open_rdata_reg.elapsed;
        closed.hits       = (acc_cur.hits == '1) ? acc_cur.hits : acc_cur.hits + HIT_W'(1);
        closed.main_total = (key_reg[KEY_W-1:SID_W] == '0)
                            ? acc_cur.main_total + open_rdata_reg.elapsed
                            : acc_cur.main_total;

        state_next     = state_reg;
        open_flag_next = open_flag_reg;
        acc_vld_next   = acc_vld_reg;
        key_next       = key_reg;
        st_next        = st_reg;
        el_next        = el_reg;
        idx_next       = idx_reg;
        frame_next     = frame_reg;
        held_next      = held_reg;
        age_next       = age_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        open_raddr     = key_reg;
        acc_raddr      = key_sid;
        open_we        = 1'b0;
        acc_we         = 1'b0;
        open_wdata     = '{start: st_reg, elapsed: el_reg};
        acc_wdata      = closed;

        unique case (state_reg)
            ST_IDLE:
            begin
                open_raddr = {in_data.thread_num, in_data.scope_id};
                acc_raddr  = in_data.scope_id;
                key_next   = {in_data.thread_num, in_data.scope_id};
                st_next    = in_data.start_tick;
                el_next    = in_data.elapsed_ticks;
                if (in_valid)
                begin
                    if (in_data.cmd == CMD_FRAME)
                    begin
                        key_next   = '0;
                        state_next = ST_CL_RD;
                    end
                    else if ({1'b0, in_data.scope_id} < n_act)
                    begin
                        state_next = ST_SMP;
                    end
                end
            end
            ST_SMP:
            begin
                if (!nested)
                begin
                    if (open_flag_reg[key_reg])
                    begin
                        acc_we            = 1'b1;
                        acc_vld_next[key_sid] = 1'b1;
                    end
                    open_we                 = 1'b1;
                    open_flag_next[key_reg] = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_CL_RD:
            begin
                state_next = ST_CL_WR;
            end
            ST_CL_WR:
            begin
                if (open_flag_reg[key_reg])
                begin
                    acc_we                  = 1'b1;
                    acc_vld_next[key_sid]   = 1'b1;
                    open_flag_next[key_reg] = 1'b0;
                end
                key_next = key_reg + KEY_W'(1);
                if (key_reg == KEY_W'(ENTRIES - 1))
                begin
                    idx_next   = '0;
                    frame_next = '0;
                    state_next = (n_act == '0) ? ST_EM_LD : ST_MX_RD;
                end
                else
                begin
                    state_next = ST_CL_RD;
                end
                open_raddr = key_next;
                acc_raddr  = key_next[SID_W-1:0];
            end
            ST_MX_RD:
            begin
                acc_raddr  = idx_reg;
                key_next   = {{TID_W{1'b0}}, idx_reg};
                state_next = ST_MX_CMP;
            end
            ST_MX_CMP:
            begin
                if (acc_cur.main_total > frame_reg)
                begin
                    frame_next = acc_cur.main_total;
                end
                if (is_last)
                begin
                    state_next = ST_MX_UPD;
                end
                else
                begin
                    idx_next   = idx_reg + SID_W'(1);
                    state_next = ST_MX_RD;
                end
            end
            ST_MX_UPD:
            begin
                age_next = age_inc;
                if (age_inc > REFRESH_FRAMES || frame_reg > held_reg)
                begin
                    age_next  = '0;
                    held_next = frame_reg;
                end
                idx_next   = '0;
                state_next = ST_EM_RD;
            end
            ST_EM_RD:
            begin
                acc_raddr  = idx_reg;
                key_next   = {{TID_W{1'b0}}, idx_reg};
                state_next = ST_EM_LD;
            end
            ST_EM_LD:
            begin
                acc_raddr = idx_reg;
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (n_act == '0)
                    begin
                        out_next                 = '0;
                        out_next.max_frame_ticks = held_reg;
                        out_next.last            = 1'b1;
                    end
                    else
                    begin
                        out_next.scope_valid     = 1'b1;
                        out_next.scope_index     = idx_reg;
                        out_next.total_ticks     = acc_cur.total;
                        out_next.hit_count       = acc_cur.hits;
                        out_next.frame_ticks     = frame_reg;
                        out_next.max_frame_ticks = held_reg;
                        out_next.last            = is_last;
                    end
                    if (is_last)
                    begin
                        acc_vld_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + SID_W'(1);
                        state_next = ST_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scopes_reg    <= '0;
            open_flag_reg <= '0;
            acc_vld_reg   <= '0;
            held_reg      <= '0;
            age_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_flag_reg <= open_flag_next;
            acc_vld_reg   <= acc_vld_next;
            held_reg      <= held_next;
            age_reg       <= age_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                scopes_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        st_reg    <= st_next;
        el_reg    <= el_next;
        idx_reg   <= idx_next;
        frame_reg <= frame_next;
        out_reg   <= out_next;
    end

endmodule

// ===== sim/nested_interval_time_accumulator_unit_tb.sv =====
`timescale 1ns / 1ps

class frame_report_board;
    bit              open_flag [nita_pkg::THREADS][nita_pkg::SCOPES];
    logic [31:0]     open_start [nita_pkg::THREADS][nita_pkg::SCOPES];
    logic [31:0]     open_len [nita_pkg::THREADS][nita_pkg::SCOPES];
    logic [31:0]     scope_sum [nita_pkg::SCOPES];
    logic [15:0]     scope_hits [nita_pkg::SCOPES];
    logic [31:0]     main_sum [nita_pkg::SCOPES];
    logic [31:0]     held_max;
    int unsigned     frames_since;
    int unsigned     scopes_cfg;
    nita_pkg::out_t  pending_reports [$];
    int              errors;

    function new();
        for (int t = 0; t < nita_pkg::THREADS; t++)
            for (int s = 0; s < nita_pkg::SCOPES; s++)
            begin
                open_flag[t][s] = 0;
                open_start[t][s] = 0;
                open_len[t][s] = 0;
            end
        clear_totals();
        held_max = 0;
        frames_since = 0;
        scopes_cfg = 0;
        errors = 0;
    endfunction

    function void clear_totals();
        for (int s = 0; s < nita_pkg::SCOPES; s++)
        begin
            scope_sum[s] = 0;
            scope_hits[s] = 0;
            main_sum[s] = 0;
        end
    endfunction

    function void close_sample(int t, int s);
        scope_sum[s] += open_len[t][s];
        if (scope_hits[s] != 16'hFFFF)
            scope_hits[s]++;
        if (t == 0)
            main_sum[s] += open_len[t][s];
        open_flag[t][s] = 0;
    endfunction

    function void note_transfer(nita_pkg::in_t it);
        int unsigned n;
        logic [31:0] stop;
        logic [31:0] frame;
        nita_pkg::out_t r;
        n = (scopes_cfg > nita_pkg::SCOPES) ? nita_pkg::SCOPES : scopes_cfg;
        if (it.cmd == nita_pkg::CMD_RECORD)
        begin
            if (it.scope_id >= n)
                return;
            if (open_flag[it.thread_num][it.scope_id])
            begin
                stop = open_start[it.thread_num][it.scope_id]
                       + open_len[it.thread_num][it.scope_id];
                if (it.start_tick >= open_start[it.thread_num][it.scope_id]
                    && it.start_tick < stop)
                    return;
                close_sample(it.thread_num, it.scope_id);
            end
            open_flag[it.thread_num][it.scope_id] = 1;
            open_start[it.thread_num][it.scope_id] = it.start_tick;
            open_len[it.thread_num][it.scope_id] = it.elapsed_ticks;
            return;
        end
        for (int t = 0; t < nita_pkg::THREADS; t++)
            for (int s = 0; s < nita_pkg::SCOPES; s++)
                if (open_flag[t][s])
                    close_sample(t, s);
        if (n == 0)
        begin
            r = '0;
            r.max_frame_ticks = held_max;
            r.last = 1;
            pending_reports.push_back(r);
        end
        else
        begin
            frame = main_sum[0];
            for (int i = 1; i < n; i++)
                if (main_sum[i] > frame)
                    frame = main_sum[i];
            frames_since++;
            if (frames_since > 60 || frame > held_max)
            begin
                frames_since = 0;
                held_max = frame;
            end
            for (int i = 0; i < n; i++)
            begin
                r.scope_valid = 1;
                r.scope_index = 4'(i);
                r.total_ticks = scope_sum[i];
                r.hit_count = scope_hits[i];
                r.frame_ticks = frame;
                r.max_frame_ticks = held_max;
                r.last = (i + 1 == n);
                pending_reports.push_back(r);
            end
        end
        clear_totals();
    endfunction

    function void check_report(nita_pkg::out_t got);
        nita_pkg::out_t exp;
        if (pending_reports.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp = pending_reports.pop_front();
        if (got !== exp)
        begin
            $display("%0t: mismatch expected %h actual %h", $time, exp, got);
            errors++;
        end
    endfunction
endclass

module nested_interval_time_accumulator_unit_tb;
    import nita_pkg::*;

    logic             clk = 0;
    logic             rst_n = 0;
    logic             cfg_wr_en = 0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             in_valid = 0;
    logic             in_stall;
    in_t              in_data = '0;
    logic             out_valid;
    logic             out_stall = 0;
    out_t             out_data;

    frame_report_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic [31:0] base_tick = 0;

    nested_interval_time_accumulator_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_report(out_data);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_item(in_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_transfer(it);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 0;
        while (board.pending_reports.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (300) @(posedge clk);
    endtask

    task automatic write_scopes(int unsigned n);
        drain();
        cfg_wr_en <= 1;
        cfg_wr_data <= CNT_W'(n);
        @(posedge clk);
        cfg_wr_en <= 0;
        board.scopes_cfg = n & 31;
    endtask

    task automatic send_sample(int t, int s, logic [31:0] st, logic [31:0] el);
        in_t it;
        it = '0;
        it.cmd = CMD_RECORD;
        it.thread_num = TID_W'(t);
        it.scope_id = SID_W'(s);
        it.start_tick = st;
        it.elapsed_ticks = el;
        send_item(it);
    endtask

    task automatic send_frame();
        in_t it;
        logic [95:0] rnd;
        rnd = {$urandom, $urandom, $urandom};
        it = rnd[$bits(in_t)-1:0];
        it.cmd = CMD_FRAME;
        send_item(it);
    endtask

    task automatic random_item(int unsigned n);
        int t;
        int s;
        logic [31:0] st;
        t = $urandom_range(3);
        s = $urandom_range(n + 1 > 15 ? 15 : n + 1);
        case ($urandom_range(9))
            0: send_frame();
            1: send_sample(t, s, $urandom, $urandom);
            2, 3: send_sample(t, s, base_tick + $urandom_range(20),
                              $urandom_range(30));
            default:
            begin
                base_tick += $urandom_range(40);
                st = base_tick;
                send_sample(t, s, st, $urandom_range(50));
            end
        endcase
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_sample(0, 0, 5, 5);
        send_frame();
        write_scopes(4);
        send_sample(0, 0, 100, 50);
        send_sample(0, 0, 120, 10);
        send_sample(0, 0, 149, 1);
        send_sample(0, 0, 150, 20);
        send_sample(1, 1, 32'hFFFF_FFF0, 32'h20);
        send_sample(1, 1, 0, 5);
        send_sample(3, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(3, 2, 32'h0, 32'h0);
        send_sample(2, 3, 10, 0);
        send_sample(2, 3, 10, 7);
        send_sample(0, 5, 1, 1);
        send_sample(0, 15, 1, 1);
        send_sample(0, 1, 7, 32'hFFFF_FFFF);
        send_sample(0, 1, 32'hFFFF_FFFF, 3);
        send_frame();
        send_frame();
        write_scopes(31);
        send_sample(3, 15, 32'hAAAA_5555, 32'h5555_AAAA);
        send_sample(2, 14, 32'h5555_AAAA, 32'hAAAA_5555);
        send_frame();
        for (int i = 0; i < 64; i++)
            send_frame();
        write_scopes(16);
        send_sample(0, 3, 0, 32'h8000_0000);
        send_sample(0, 3, 32'h8000_0000, 1);
        send_frame();
        for (int ph = 0; ph < 5; ph++)
        begin
            int unsigned n;
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  n = 1; end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  n = 16; end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; n = 3; end
                3: begin send_idle_pct = 33; recv_stall_pct = 33; n = 17; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; n = 0; end
            endcase
            write_scopes(n);
            for (int i = 0; i < 27; i++)
                random_item(n > 16 ? 16 : n);
            send_frame();
        end
        drain();
        if (board.errors == 0 && board.pending_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
